// ===== src/rpsc_pkg.sv =====
// Shared constants and types for the repeating pattern slip checker.
`timescale 1ns / 1ps
package rpsc_pkg;

  localparam int unsigned PatternDepth = 4096;
  localparam int unsigned AddrW        = $clog2(PatternDepth);
  localparam int unsigned LenW         = 13;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned SumW         = AddrW + ByteW + 1;
  localparam int unsigned SlipW        = 16;
  localparam int unsigned ChunkW       = 32;
  localparam int unsigned OutDataW     = 56;
  localparam int unsigned ApbAddrW     = 3;

  localparam logic [ApbAddrW-1:0] RegPatternBytes = ApbAddrW'(0);
  localparam logic [LenW-1:0]     PatternBytesRst = LenW'(32);
  localparam logic [LenW-1:0]     MaxLen          = LenW'(PatternDepth);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [ByteW-1:0] byte_t;

endpackage

// ===== src/rpsc_ram.sv =====
// Single-port-write, registered-read pattern memory.
`timescale 1ns / 1ps
module rpsc_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/repeating_pattern_slip_checker.sv =====
// Top level of the repeating pattern slip checker.
//
// The slave stream carries one received byte per word. The byte stream is cut
// into chunks of pattern_bytes bytes (0 acts as 1, values above 4096 as 4096),
// set through the APB register at address 0. The first chunk after reset is
// stored as the reference pattern; every later chunk is compared byte by byte
// and the signed differences (pattern minus received) are summed. At the end
// of each chunk one word leaves on the master stream: slip, the saturating
// slip count and the chunk index. After a slip the next chunk is stored again.
//
// Throughput: one byte per cycle while s_axis_tready is high; the pattern memory is
// read in the accept cycle and written (in store mode) when the byte leaves stage 1.
// The result word is registered in the output register after the last byte of a
// chunk leaves stage 1. A result waiting in the output register does not block bytes
// that are not the last of a chunk; s_axis_tready drops only when a chunk end
// would find the output register still full while m_axis_tready is low.
// Reset clears all control state and puts the block in store mode; the
// pattern memory is not cleared and needs no sweep.
`timescale 1ns / 1ps
module repeating_pattern_slip_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpsc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rpsc_pkg::OutDataW-1:0]  m_axis_tdata   // [0] slip, [16:1] slip_total,
                                                        // [48:17] chunk_number, rest 0
);
  import rpsc_pkg::*;

  // configuration
  logic [LenW-1:0] pattern_bytes_q;
  logic            cfg_we;
  logic [LenW-1:0] len;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegPatternBytes[ApbAddrW-1:2]);
  assign prdata = (paddr[ApbAddrW-1:2] == RegPatternBytes[ApbAddrW-1:2]) ?
                  {{(32-LenW){1'b0}}, pattern_bytes_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q <= PatternBytesRst;
    end else if (cfg_we) begin
      pattern_bytes_q <= pwdata[LenW-1:0];
    end
  end

  always_comb begin
    priority if (pattern_bytes_q == '0) begin
      len = LenW'(1);
    end else if (pattern_bytes_q > MaxLen) begin
      len = MaxLen;
    end else begin
      len = pattern_bytes_q;
    end
  end

  // stage 0: position counter and memory read
  logic            accept;
  addr_t           pos_q;
  addr_t           pos_d;
  logic            last0;
  logic [LenW-1:0] pos_next;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign pos_next = {1'b0, pos_q} + LenW'(1);
  assign last0    = !(pos_next < len);
  assign pos_d    = last0 ? '0 : pos_next[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  // stage 1 registers
  logic  s1_valid_q;
  byte_t s1_byte_q;
  addr_t s1_pos_q;
  logic  s1_last_q;
  logic  fwd_hit_q;
  byte_t fwd_data_q;
  logic  out_free;
  logic  s1_go;
  logic  load_q;
  logic  mem_we;
  byte_t ram_rdata;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_go         = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign mem_we        = s1_go && load_q;

  rpsc_ram #(
    .Depth (PatternDepth),
    .Width (ByteW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s1_pos_q),
    .wdata_i (s1_byte_q),
    .re_i    (accept),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q  <= s_axis_tdata;
      s1_pos_q   <= pos_q;
      s1_last_q  <= last0;
      // the store still being written here is newer than the memory read
      fwd_hit_q  <= mem_we && (s1_pos_q == pos_q);
      fwd_data_q <= s1_byte_q;
    end
  end

  // stage 1: accumulate and finish the chunk
  byte_t                  pat;
  logic signed [ByteW:0]  diff;
  logic signed [SumW-1:0] sum_q;
  logic signed [SumW-1:0] sum_new;
  logic                   slip;
  logic [SlipW-1:0]       slip_cnt_q;
  logic [SlipW-1:0]       slip_cnt_d;
  logic [ChunkW-1:0]      chunk_cnt_q;

  assign pat     = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign diff    = $signed({pat[ByteW-1], pat}) - $signed({s1_byte_q[ByteW-1], s1_byte_q});
  assign sum_new = load_q ? sum_q : sum_q + SumW'(diff);
  assign slip    = !load_q && (sum_new != '0);
  assign slip_cnt_d = (slip && (slip_cnt_q != '1)) ? slip_cnt_q + SlipW'(1) : slip_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      load_q      <= 1'b1;
      slip_cnt_q  <= '0;
      chunk_cnt_q <= '0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        sum_q       <= '0;
        load_q      <= slip;
        slip_cnt_q  <= slip_cnt_d;
        chunk_cnt_q <= chunk_cnt_q + ChunkW'(1);
      end else begin
        sum_q <= sum_new;
      end
    end
  end

  // output register
  logic              out_valid_q;
  logic              out_slip_q;
  logic [SlipW-1:0]  out_total_q;
  logic [ChunkW-1:0] out_chunk_q;
  logic              out_load;

  assign out_load = s1_go && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slip_q  <= slip;
      out_total_q <= slip_cnt_d;
      out_chunk_q <= chunk_cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-1-SlipW-ChunkW){1'b0}}, out_chunk_q, out_total_q, out_slip_q};

endmodule

// ===== src/rpsc_checker.sv =====
// Port-level checks on the slip checker's result stream, bound to the top level.
`timescale 1ns / 1ps
module rpsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rpsc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          pready
);
  import rpsc_pkg::*;

  logic              seen_q;
  logic              prev_slip_q;
  logic [SlipW-1:0]  prev_total_q;
  logic [ChunkW-1:0] prev_chunk_q;
  logic              out_acc;
  logic              cur_slip;
  logic [SlipW-1:0]  cur_total;
  logic [ChunkW-1:0] cur_chunk;

  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign cur_slip  = m_axis_tdata[0];
  assign cur_total = m_axis_tdata[SlipW:1];
  assign cur_chunk = m_axis_tdata[SlipW+ChunkW:SlipW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      prev_slip_q  <= 1'b0;
      prev_total_q <= '0;
      prev_chunk_q <= '0;
    end else if (out_acc) begin
      seen_q       <= 1'b1;
      prev_slip_q  <= cur_slip;
      prev_total_q <= cur_total;
      prev_chunk_q <= cur_chunk;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // chunk indices advance by one from word to word
  a_chunk_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> cur_chunk == prev_chunk_q + ChunkW'(1))
    else $error("chunk index skipped or repeated");

  // the chunk after a slip is stored again and cannot slip
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && prev_slip_q |-> !cur_slip)
    else $error("slip reported on a reload chunk");

  // slip count moves by one on a slip (unless full) and holds otherwise
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> (cur_slip && prev_total_q != '1) ?
      (cur_total == prev_total_q + SlipW'(1)) : (cur_total == prev_total_q))
    else $error("slip count out of step");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("register port not ready");

endmodule

bind repeating_pattern_slip_checker rpsc_checker u_rpsc_checker (.*);
